>>> src/tkss_pkg.sv
package tkss_pkg;

	// Store geometry
	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed field widths
	localparam int SCORE_W   = 32;
	localparam int SLOT_W    = 5;
	localparam int WC_W      = 6;
	localparam int RND_W     = (CNT_W > WC_W) ? CNT_W : WC_W;
	localparam logic [WC_W-1:0] WC_RESET = WC_W'(1);

	// Input item as seen on the push side
	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic                      occupied;
		logic                      last_in;
	} in_item_t;

	// Result item as seen on the pop side
	typedef struct packed {
		logic [SLOT_W-1:0]         slot_id;
		logic signed [SCORE_W-1:0] score_out;
		logic                      occupied_out;
		logic                      last_out;
	} out_item_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic                      occupied;
		logic                      last_in;
		logic                      drop;
		logic [IDX_W-1:0]          idx;
	} task_t;

	// One store entry
	typedef struct packed {
		logic [SLOT_W-1:0]         slot_id;
		logic signed [SCORE_W-1:0] score;
		logic                      occupied;
	} entry_t;

endpackage

>>> src/tkss_front.sv
module tkss_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  tkss_pkg::in_item_t item,
	output logic              q_valid,
	input  logic              q_pop,
	output tkss_pkg::task_t   q_data
);
	import tkss_pkg::*;

	logic [CNT_W-1:0] count_q;
	task_t            fifo_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;
	logic             accept;
	logic             drop;
	task_t            tsk;

	// Classify: slot position in the batch, or drop when the store is full
	assign accept = push && !full;
	assign drop   = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		tsk.score    = item.score;
		tsk.occupied = item.occupied;
		tsk.last_in  = item.last_in;
		tsk.drop     = drop;
		tsk.idx      = count_q[IDX_W-1:0];
	end

	// Batch position counter, cleared by the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (item.last_in) begin
				count_q <= '0;
			end else if (!drop) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Two-entry queue toward the back
	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data  = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			fifo_q[wp_q] <= tsk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accept) begin
				wp_q <= ~wp_q;
			end
			if (q_pop && q_valid) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, accept} - {1'b0, q_pop && q_valid};
		end
	end

endmodule

>>> src/tkss_back.sv
module tkss_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  tkss_pkg::task_t    q_data,
	input  logic               winners_we,
	input  logic [5:0]         winners_count,
	output logic               empty,
	input  logic               pop,
	output tkss_pkg::out_item_t result
);
	import tkss_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [WC_W-1:0]  wc_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] rounds_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] rd_ptr_q;
	entry_t           best_q;
	entry_t           jent_q;
	logic [IDX_W-1:0] best_idx_q;

	// Entry store, one write and one registered read per cycle
	entry_t           mem_q [CAPACITY];
	entry_t           rdata_s1;
	logic             rvalid_s1;
	logic [IDX_W-1:0] ridx_s1;

	logic             mem_we;
	logic [IDX_W-1:0] waddr;
	entry_t           wdata;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;

	logic [CNT_W-1:0] load_n;
	logic [CNT_W-1:0] load_rounds;
	logic [CNT_W-1:0] next_j;
	logic             scan_hit;
	logic             at_j;
	logic             better;
	logic             at_end;
	logic             do_swap;

	// Output queue
	out_item_t        ofifo_q [2];
	logic             owp_q;
	logic             orp_q;
	logic [1:0]       ocnt_q;
	logic             o_push;
	logic             o_pop;
	out_item_t        o_item;

	// Control decode
	assign q_pop    = (state_q == ST_LOAD) && q_valid;
	assign o_pop    = pop && !empty;
	assign rd_addr  = rd_ptr_q[IDX_W-1:0];
	assign next_j   = j_q + CNT_W'(1);
	assign scan_hit = (state_q == ST_SCAN) && rvalid_s1;
	assign at_j     = (ridx_s1 == j_q[IDX_W-1:0]);
	assign better   = at_j || ($signed(rdata_s1.score) > $signed(best_q.score));
	assign at_end   = (CNT_W'(ridx_s1) == n_q - CNT_W'(1));
	assign do_swap  = (best_idx_q != j_q[IDX_W-1:0]) && best_q.occupied;
	assign o_push   = (state_q == ST_EMIT) && rvalid_s1;

	// Batch size and round count at the last entry
	always_comb begin
		load_n = q_data.drop ? CNT_W'(CAPACITY) : (CNT_W'(q_data.idx) + CNT_W'(1));
		if (RND_W'(wc_q) < RND_W'(load_n)) begin
			load_rounds = CNT_W'(wc_q);
		end else begin
			load_rounds = load_n;
		end
	end

	// Read issue: scans run freely, emission is held back by output space
	always_comb begin
		rd_en = 1'b0;
		if (state_q == ST_SCAN) begin
			rd_en = (rd_ptr_q < n_q);
		end else if (state_q == ST_EMIT) begin
			rd_en = (rd_ptr_q < n_q) &&
				((ocnt_q - {1'b0, o_pop} + {1'b0, rvalid_s1}) < 2'd2);
		end
	end

	// Store write port
	always_comb begin
		mem_we = 1'b0;
		waddr  = q_data.idx;
		wdata  = '{slot_id: SLOT_W'(q_data.idx), score: q_data.score,
			occupied: q_data.occupied};
		case (state_q)
			ST_LOAD: begin
				mem_we = q_pop && !q_data.drop;
			end
			ST_SWAP_A: begin
				mem_we = do_swap;
				waddr  = j_q[IDX_W-1:0];
				wdata  = best_q;
			end
			ST_SWAP_B: begin
				mem_we = 1'b1;
				waddr  = best_idx_q;
				wdata  = jent_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_s1 <= mem_q[rd_addr];
	end

	// Sequencer: load, scan rounds with swaps, then emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			wc_q       <= WC_RESET;
			n_q        <= '0;
			rounds_q   <= '0;
			j_q        <= '0;
			rd_ptr_q   <= '0;
			rvalid_s1  <= 1'b0;
			ridx_s1    <= '0;
			best_q     <= '0;
			jent_q     <= '0;
			best_idx_q <= '0;
		end else begin
			if (winners_we) begin
				wc_q <= winners_count;
			end
			rvalid_s1 <= rd_en;
			ridx_s1   <= rd_addr;
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + CNT_W'(1);
			end
			case (state_q)
				ST_LOAD: begin
					if (q_pop && q_data.last_in) begin
						n_q      <= load_n;
						rounds_q <= load_rounds;
						j_q      <= '0;
						rd_ptr_q <= '0;
						state_q  <= (load_rounds == '0) ? ST_EMIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_hit && better) begin
						best_q     <= rdata_s1;
						best_idx_q <= ridx_s1;
					end
					if (scan_hit && at_j) begin
						jent_q <= rdata_s1;
					end
					if (scan_hit && at_end) begin
						state_q <= ST_SWAP_A;
					end
				end
				ST_SWAP_A, ST_SWAP_B: begin
					if (state_q == ST_SWAP_A && do_swap) begin
						state_q <= ST_SWAP_B;
					end else begin
						j_q <= next_j;
						if (next_j == rounds_q) begin
							rd_ptr_q <= '0;
							state_q  <= ST_EMIT;
						end else begin
							rd_ptr_q <= next_j;
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_EMIT: begin
					if (o_push && at_end) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Result formatting and output queue
	always_comb begin
		o_item.slot_id      = rdata_s1.slot_id;
		o_item.score_out    = rdata_s1.score;
		o_item.occupied_out = rdata_s1.occupied;
		o_item.last_out     = at_end;
	end

	assign empty  = (ocnt_q == 2'd0);
	assign result = ofifo_q[orp_q];

	always_ff @(posedge clk) begin
		if (o_push) begin
			ofifo_q[owp_q] <= o_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (o_push) begin
				owp_q <= ~owp_q;
			end
			if (o_pop) begin
				orp_q <= ~orp_q;
			end
			ocnt_q <= ocnt_q + {1'b0, o_push} - {1'b0, o_pop};
		end
	end

	// Output queue never takes a transfer it has no room for
	assert property (@(posedge clk) disable iff (!arst_n)
		(o_push && !o_pop) |-> (ocnt_q != 2'd2))
		else $error("output queue overflow");

	// Scan data always belongs to the current round's range
	assert property (@(posedge clk) disable iff (!arst_n)
		scan_hit |-> ((CNT_W'(ridx_s1) >= j_q) && (CNT_W'(ridx_s1) < n_q)))
		else $error("scan read outside round range");

	// Second half of a swap only follows a taken first half
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWAP_B) |-> ($past(state_q) == ST_SWAP_A))
		else $error("swap sequence broken");

	// Last marker is only produced once all reads of the batch are issued
	assert property (@(posedge clk) disable iff (!arst_n)
		(o_push && at_end) |-> (rd_ptr_q == n_q))
		else $error("last result before batch fully read");

endmodule

>>> src/top_k_selection_sorter_unit.sv
// Top-k selection sorter. Entries are pushed one per transfer; each is
// stored with its arrival index until the store (32 slots) is full, after
// which entries are dropped. The entry carrying last_in closes the batch:
// the unit runs min(winners_count, n) selection rounds over the n stored
// entries, moving the first strictly greatest score at or after position j
// into position j (unoccupied entries are never moved forward), then emits
// all n entries in their new order with last_out on the final one.
// Loading passes each entry through a two-deep input queue. Sorting
// is bound by the single read port of the entry store: round j scans the
// n - j entries from position j at one compare per cycle, then decides in
// ST_SWAP_A and writes the second half of a swap in ST_SWAP_B when one is
// taken; emission then reads all n entries at one result per cycle while
// results are popped without stalls. The input queue keeps accepting up to
// two entries of the next batch during that time.
// winners_count resets to 1 and should only be written while the unit is idle.
module top_k_selection_sorter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  tkss_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output tkss_pkg::out_item_t result,
	input  logic                winners_we,
	input  logic [5:0]          winners_count
);
	import tkss_pkg::*;

	logic  q_valid;
	logic  q_pop;
	task_t q_data;

	// Front: accept and classify entries
	tkss_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_data  (q_data)
	);

	// Back: store, select rounds and emit
	tkss_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_data        (q_data),
		.winners_we    (winners_we),
		.winners_count (winners_count),
		.empty         (empty),
		.pop           (pop),
		.result        (result)
	);

endmodule
